// ===== src/kdle_pkg.sv =====
package kdle_pkg;

  // segment geometry
  localparam int SEGMENT_BYTES = 8;
  localparam int FILL_W = $clog2(SEGMENT_BYTES + 1);

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // marker and pad bytes
  localparam logic [7:0] MARK_MINUS_INF = 8'h01;
  localparam logic [7:0] MARK_END_BASE  = 8'h02;
  localparam logic [7:0] MARK_CONTINUES = 8'hFE;
  localparam logic [7:0] MARK_PLUS_INF  = 8'hFF;
  localparam logic [7:0] PAD_ZERO       = 8'h00;
  localparam logic [7:0] PAD_ONES       = 8'hFF;

  // action codes
  localparam logic ACT_CONTENT = 1'b0;
  localparam logic ACT_END     = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       minus_infinity;
    logic       plus_infinity;
    logic       next_flag;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // one classified item: optional continuation, pad run, closing byte
  typedef struct packed {
    logic              cont;
    logic [FILL_W-1:0] pad_count;
    logic [7:0]        pad_byte;
    logic [7:0]        final_byte;
  } cmd_t;

endpackage

// ===== src/kdle_queue.sv =====
module kdle_queue
  import kdle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t rdata
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = slots[rd_ptr];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== src/kdle_front.sv =====
module kdle_front
  import kdle_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t item,
  output cmd_t     cmd
);

  logic [FILL_W-1:0] segment_fill;
  logic [FILL_W-1:0] segment_fill_next;
  logic              seg_full;
  logic [7:0]        end_mark;

  assign seg_full = (segment_fill == FILL_W'(SEGMENT_BYTES));
  assign end_mark = MARK_END_BASE + 8'({segment_fill, 1'b0}) + 8'(item.next_flag);

  // classify the item into a command for the back end
  always_comb begin
    cmd               = '0;
    segment_fill_next = segment_fill;
    if (item.action == ACT_CONTENT) begin
      cmd.cont       = seg_full;
      cmd.pad_count  = '0;
      cmd.pad_byte   = PAD_ZERO;
      cmd.final_byte = item.data_byte;
      segment_fill_next = seg_full ? FILL_W'(1) : segment_fill + 1'b1;
    end else begin
      cmd.cont          = 1'b0;
      segment_fill_next = '0;
      if (item.minus_infinity) begin
        cmd.pad_count  = FILL_W'(SEGMENT_BYTES);
        cmd.pad_byte   = PAD_ZERO;
        cmd.final_byte = MARK_MINUS_INF;
      end else if (item.plus_infinity) begin
        cmd.pad_count  = FILL_W'(SEGMENT_BYTES);
        cmd.pad_byte   = PAD_ONES;
        cmd.final_byte = MARK_PLUS_INF;
      end else begin
        cmd.pad_count  = FILL_W'(SEGMENT_BYTES) - segment_fill;
        cmd.pad_byte   = PAD_ZERO;
        cmd.final_byte = end_mark;
      end
    end
  end

  // open segment fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_fill <= '0;
    end else if (accept) begin
      segment_fill <= segment_fill_next;
    end
  end

endmodule

// ===== src/kdle_back.sv =====
module kdle_back
  import kdle_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  cmd_t      q_data,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  cmd_t      cur;
  logic      cur_valid;
  logic      out_valid;
  out_item_t out_reg;
  out_item_t emit;
  logic      out_ready;
  logic      advance;
  logic      emit_final;

  assign out_ready  = !out_valid || pop;
  assign advance    = cur_valid && out_ready;
  assign emit_final = !cur.cont && (cur.pad_count == '0);
  assign q_pop      = q_valid && (!cur_valid || (advance && emit_final));
  assign empty      = !out_valid;
  assign result     = out_reg;

  // byte the current command gives next
  always_comb begin
    if (cur.cont) begin
      emit.out_byte = MARK_CONTINUES;
      emit.run_last = 1'b0;
    end else if (cur.pad_count != '0) begin
      emit.out_byte = cur.pad_byte;
      emit.run_last = 1'b0;
    end else begin
      emit.out_byte = cur.final_byte;
      emit.run_last = 1'b1;
    end
  end

  // valid flags of the sequencer and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (advance && emit_final) begin
        cur_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // command sequencing and output data
  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= emit;
    end
    if (q_pop) begin
      cur <= q_data;
    end else if (advance) begin
      if (cur.cont) begin
        cur.cont <= 1'b0;
      end else if (cur.pad_count != '0) begin
        cur.pad_count <= cur.pad_count - 1'b1;
      end
    end
  end

endmodule

// ===== src/key_dimension_lace_encoder_unit.sv =====
// an accepted item passes the queue and the sequencer's command register before the output register
// throughput: one result byte per cycle, set by the output sequencer, while pop is held
// a content byte gives 1 result byte (2 when it opens a new segment)
// an end gives SEGMENT_BYTES + 1 - fill bytes, an infinity SEGMENT_BYTES + 1
// synchronous active-high reset clears segment fill, queue and output
module key_dimension_lace_encoder_unit
  import kdle_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  cmd_t front_cmd;
  cmd_t q_data;
  logic q_valid;
  logic q_pop;
  logic accept;

  assign accept = push && !full;

  // classify incoming items
  kdle_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cmd    (front_cmd)
  );

  // decoupling queue
  kdle_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (front_cmd),
    .full  (full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_data)
  );

  // expand commands into bytes
  kdle_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== src/kdle_checker.sv =====
module kdle_checker
  import kdle_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  // reset leaves nothing to deliver
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  // reset leaves room for input
  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  // a waiting result holds until it is transferred
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

  // a non-final byte is a pad or a continuation marker
  a_inner_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.run_last) |->
      (result.out_byte == PAD_ZERO || result.out_byte == PAD_ONES ||
       result.out_byte == MARK_CONTINUES))
    else $error("unexpected byte inside a run");

endmodule

bind key_dimension_lace_encoder_unit kdle_checker u_kdle_checker (.*);

// ===== sim/kdle_lace_checker.sv =====
module kdle_lace_checker
  import kdle_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_item_t  item,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t result,
  output int        mismatches,
  output int        waiting,
  output int        checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // bytes still owed by the block, oldest first
  out_item_t         lace_bytes[$];
  // content bytes in the open segment
  logic [FILL_W-1:0] lace_fill;
  out_item_t         want;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // lace one input item into the expected byte stream
  task automatic lace_encode(input in_item_t it);
    logic [7:0] pad;
    logic [7:0] mark;
    int         pad_len;
    if (it.action == ACT_CONTENT) begin
      // full segment: continuation marker opens the next one
      if (lace_fill == SEGMENT_BYTES) begin
        lace_bytes.push_back('{out_byte: MARK_CONTINUES, run_last: 1'b0});
        lace_fill = '0;
      end
      lace_bytes.push_back('{out_byte: it.data_byte, run_last: 1'b1});
      lace_fill++;
    end else begin
      // minus infinity wins over plus infinity, next flag only on a plain end
      if (it.minus_infinity) begin
        pad     = PAD_ZERO;
        pad_len = SEGMENT_BYTES;
        mark    = MARK_MINUS_INF;
      end else if (it.plus_infinity) begin
        pad     = PAD_ONES;
        pad_len = SEGMENT_BYTES;
        mark    = MARK_PLUS_INF;
      end else begin
        pad     = PAD_ZERO;
        pad_len = SEGMENT_BYTES - lace_fill;
        mark    = 8'(MARK_END_BASE + 2 * lace_fill + it.next_flag);
      end
      repeat (pad_len) lace_bytes.push_back('{out_byte: pad, run_last: 1'b0});
      lace_bytes.push_back('{out_byte: mark, run_last: 1'b1});
      lace_fill = '0;
    end
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      lace_bytes.delete();
      lace_fill  = '0;
      mismatches = 0;
      checked    = 0;
    end else begin
      // result transfer against the oldest expected byte
      if (pop && !empty) begin
        if (lace_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b",
                                    result.out_byte, result.run_last));
        end else begin
          want = lace_bytes.pop_front();
          if (result.out_byte !== want.out_byte)
            report_mismatch($sformatf("byte %0d: out_byte %02h, expected %02h",
                                      checked, result.out_byte, want.out_byte));
          if (result.run_last !== want.run_last)
            report_mismatch($sformatf("byte %0d: run_last %0b, expected %0b",
                                      checked, result.run_last, want.run_last));
          checked++;
        end
      end
      // input transfer
      if (push && !full) lace_encode(item);
    end
    waiting = lace_bytes.size();
  end

endmodule

// ===== sim/key_dimension_lace_encoder_unit_tb.sv =====
module key_dimension_lace_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kdle_pkg::*;

  localparam int RANDOM_ITEMS = 320;

  logic      clk  = 1'b0;
  logic      rst  = 1'b1;
  logic      push = 1'b0;
  logic      pop  = 1'b0;
  in_item_t  item = '0;
  logic      full;
  logic      empty;
  out_item_t result;

  int mismatches;
  int waiting;
  int checked;

  // stimulus tallies for the summary
  int items_sent = 0;
  int ends_sent  = 0;
  int infs_sent  = 0;
  int conts_sent = 0;

  // calm stretches with no idling on either side
  bit push_calm = 1'b0;
  bit pop_calm  = 1'b0;

  always #10 clk = ~clk;

  key_dimension_lace_encoder_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  kdle_lace_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .mismatches (mismatches),
    .waiting    (waiting),
    .checked    (checked)
  );

  // idle length: mostly none or short, now and then long
  function automatic int idle_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_item_t make_item(input logic act, input logic [7:0] data,
                                         input logic minus, input logic plus,
                                         input logic next);
    in_item_t it;
    it.action         = act;
    it.data_byte      = data;
    it.minus_infinity = minus;
    it.plus_infinity  = plus;
    it.next_flag      = next;
    return it;
  endfunction

  // one input transfer, called and returning at a falling edge
  task automatic send_item(input in_item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) push_calm = !push_calm;
    gap = idle_gap(push_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    @(negedge clk);
    items_sent++;
    if (it.action == ACT_END) begin
      ends_sent++;
      if (it.minus_infinity || it.plus_infinity) infs_sent++;
    end else begin
      conts_sent++;
    end
  endtask

  task automatic send_content(input logic [7:0] data);
    send_item(make_item(ACT_CONTENT, data, 1'($urandom), 1'($urandom), 1'($urandom)));
  endtask

  // result side: random stalls, pop held until a transfer
  initial begin : drain
    int gap;
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) pop_calm = !pop_calm;
      gap = idle_gap(pop_calm);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  // input side and verdict
  initial begin : stimulus
    int r;
    int dim_len;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // full segment of content, end flags on content must be ignored
    send_item(make_item(ACT_CONTENT, 8'h00, 1'b1, 1'b1, 1'b1));
    send_item(make_item(ACT_CONTENT, 8'hFF, 1'b0, 1'b0, 1'b0));
    for (int i = 0; i < SEGMENT_BYTES - 2; i++) send_content(8'($urandom));
    // ninth byte opens a new segment
    send_content(8'h80);
    // plain end, data byte ignored
    send_item(make_item(ACT_END, 8'hFF, 1'b0, 1'b0, 1'b0));
    // empty dimension with next flag
    send_item(make_item(ACT_END, 8'h00, 1'b0, 1'b0, 1'b1));
    // the infinities, next flag ignored, minus wins when both are set
    send_item(make_item(ACT_END, 8'h5A, 1'b1, 1'b0, 1'b0));
    send_item(make_item(ACT_END, 8'hA5, 1'b0, 1'b1, 1'b1));
    send_item(make_item(ACT_END, 8'h00, 1'b1, 1'b1, 1'b1));
    // exactly full segment closed with next flag
    for (int i = 0; i < SEGMENT_BYTES; i++) send_content(8'($urandom));
    send_item(make_item(ACT_END, 8'h00, 1'b0, 1'b0, 1'b1));
    // infinity after content
    send_content(8'h7F);
    send_item(make_item(ACT_END, 8'h00, 1'b0, 1'b1, 1'b0));

    // random part: mostly whole dimensions, some stray items
    while (items_sent < 25 + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        r = $urandom_range(0, 99);
        if (r < 20)      dim_len = $urandom_range(0, 2);
        else if (r < 45) dim_len = $urandom_range(SEGMENT_BYTES - 1, SEGMENT_BYTES + 1);
        else if (r < 55) dim_len = $urandom_range(2 * SEGMENT_BYTES - 1, 2 * SEGMENT_BYTES + 1);
        else             dim_len = $urandom_range(0, 12);
        repeat (dim_len) send_content(8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 70)
          send_item(make_item(ACT_END, 8'($urandom), 1'b0, 1'b0, 1'($urandom)));
        else if (r < 85)
          send_item(make_item(ACT_END, 8'($urandom), 1'b1, 1'($urandom), 1'($urandom)));
        else
          send_item(make_item(ACT_END, 8'($urandom), 1'b0, 1'b1, 1'($urandom)));
      end else begin
        send_item(in_item_t'($urandom));
      end
    end
    push <= 1'b0;

    // let every expected byte arrive, then a few quiet cycles
    while (waiting != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("run: %0d items (%0d content, %0d ends, %0d of them infinite)",
             items_sent, conts_sent, ends_sent, infs_sent);
    $display("run: %0d result bytes compared, %0d mismatches", checked, mismatches);
    if (mismatches == 0) begin
      $display("key_dimension_lace_encoder_unit test passed");
    end else begin
      $display("key_dimension_lace_encoder_unit test failed");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #15_000_000;
    $display("timeout with %0d bytes outstanding", waiting);
    $display("key_dimension_lace_encoder_unit test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/kdle_pkg.sv
src/kdle_queue.sv
src/kdle_front.sv
src/kdle_back.sv
src/key_dimension_lace_encoder_unit.sv
src/kdle_checker.sv
sim/kdle_lace_checker.sv
sim/key_dimension_lace_encoder_unit_tb.sv
